@@ rtl/swcf_pkg.sv @@
// ----------------------------------------------------------------------------
// swcf_pkg
// Shared widths, codes, state encoding and the CRC-16 step for the framer.
// ----------------------------------------------------------------------------
package swcf_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

  // operation codes on the input word
  localparam logic OP_PAYLOAD = 1'b0;
  localparam logic OP_REPLY   = 1'b1;

  // result kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NAK    = 1'b1;

  localparam logic [BYTE_W-1:0] HEADER_RST = 8'd32;
  localparam logic [BYTE_W-1:0] NAK_RST    = 8'd48;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_WAIT = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_ACK  = 4'b1000
  } state_e;

  typedef struct packed {
    logic en;       // fold one byte in
    logic restart;  // start from CRC_INIT instead of the held value
  } crc_ctrl_t;

  // CRC-16 CCITT (poly 0x1021, msb first), one byte per call
  function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0]  crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] x;
    x = {8'h00, crc[15:8] ^ b};
    x = x ^ (x >> 4);
    return (crc << 8) ^ (x << 12) ^ (x << 5) ^ x;
  endfunction

endpackage

@@ rtl/swcf_in_if.sv @@
// ----------------------------------------------------------------------------
// swcf_in_if
// Input channel: payload or reply byte with valid/ready.
// ----------------------------------------------------------------------------
interface swcf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [swcf_pkg::BYTE_W-1:0] byte_value;

  modport source (output valid, operation, byte_value, input ready);
  modport sink   (input valid, operation, byte_value, output ready);
endinterface

@@ rtl/swcf_out_if.sv @@
// ----------------------------------------------------------------------------
// swcf_out_if
// Result channel: frame bytes and acknowledge with valid/ready.
// ----------------------------------------------------------------------------
interface swcf_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [swcf_pkg::BYTE_W-1:0] tx_byte;
  logic                        frame_last;

  modport source (output valid, kind, tx_byte, frame_last, input ready);
  modport sink   (input valid, kind, tx_byte, frame_last, output ready);
endinterface

@@ rtl/swcf_crc.sv @@
// ----------------------------------------------------------------------------
// swcf_crc
// CRC-16 accumulator, one byte per cycle while enabled, restartable.
// ----------------------------------------------------------------------------
module swcf_crc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  swcf_pkg::crc_ctrl_t         ctrl_i,
  input  logic [swcf_pkg::BYTE_W-1:0] byte_i,
  output logic [swcf_pkg::CRC_W-1:0]  crc_o
);

  logic [swcf_pkg::CRC_W-1:0] crc_q, crc_d, seed;

  assign seed  = ctrl_i.restart ? swcf_pkg::CRC_INIT : crc_q;
  assign crc_d = ctrl_i.en ? swcf_pkg::crc16_step(seed, byte_i) : crc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= swcf_pkg::CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

@@ rtl/stop_and_wait_crc_framer.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_crc_framer
// Stop-and-wait transmitter: stores payload, sends header+payload+CRC low
// byte, resends on an all-NAK reply, acknowledges otherwise.
// ----------------------------------------------------------------------------
// Frame start: after the last payload word (or last reply word) is accepted,
//   the state register moves to emit, then the output register takes the first
//   frame byte; frame bytes follow one per cycle while the result side is ready.
// Throughput: 1 input word per cycle while loading or collecting a reply;
//   input is held off while a frame is emitted (one byte per cycle through the
//   CRC step and the payload RAM read port) and until an acknowledge is loaded.
// Reset: asynchronous, active low; control, counters, CRC and config return
//   to defaults. The payload RAM is not cleared.
// ----------------------------------------------------------------------------
module stop_and_wait_crc_framer #(
  parameter int unsigned PAYLOAD_BYTES = 8,
  parameter int unsigned REPLY_BYTES   = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  swcf_in_if.sink                        in_if,
  swcf_out_if.source                     out_if,
  input  logic                           cfg_we_i,
  input  logic [swcf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [swcf_pkg::BYTE_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int unsigned RW = (REPLY_BYTES > 1) ? $clog2(REPLY_BYTES) : 1;
  localparam int unsigned PW = $clog2(PAYLOAD_BYTES + 2);

  localparam logic [AW-1:0] LAST_ADDR  = AW'(PAYLOAD_BYTES - 1);
  localparam logic [RW-1:0] LAST_REPLY = RW'(REPLY_BYTES - 1);
  localparam logic [PW-1:0] POS_CRC    = PW'(PAYLOAD_BYTES + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [swcf_pkg::BYTE_W-1:0] hdr_q, nak_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= swcf_pkg::HEADER_RST;
      nak_q <= swcf_pkg::NAK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        swcf_pkg::REG_HEADER: hdr_q <= cfg_data_i;
        swcf_pkg::REG_NAK:    nak_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  swcf_pkg::state_e state_q, state_d;
  logic [AW-1:0]    lcnt_q, lcnt_d;     // payload words held
  logic [RW-1:0]    rcnt_q, rcnt_d;     // reply words seen
  logic             all_nak_q, all_nak_d;
  logic [PW-1:0]    pos_q, pos_d;       // frame byte position
  logic [AW-1:0]    fptr_q, fptr_d;     // RAM read pointer

  logic in_acc, slot_free, out_load;
  logic is_payload, is_reply, reply_nak;

  assign in_if.ready = (state_q == swcf_pkg::ST_LOAD) || (state_q == swcf_pkg::ST_WAIT);
  assign in_acc      = in_if.valid && in_if.ready;
  assign is_payload  = in_acc && (in_if.operation == swcf_pkg::OP_PAYLOAD);
  assign is_reply    = in_acc && (in_if.operation == swcf_pkg::OP_REPLY);
  assign reply_nak   = all_nak_q && (in_if.byte_value == nak_q);

  // output slot may take a new word when empty or being drained
  logic out_valid_q;
  assign slot_free = !out_valid_q || out_if.ready;

  // --------------------------------------------------------------------------
  // Payload RAM: one write port (loading), one registered read port
  // (emission). Same-address write bypasses into the read register.
  // --------------------------------------------------------------------------
  logic [swcf_pkg::BYTE_W-1:0] mem [PAYLOAD_BYTES];
  logic [swcf_pkg::BYTE_W-1:0] rd_q;
  logic                        mem_we;

  assign mem_we = is_payload && (state_q == swcf_pkg::ST_LOAD);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[lcnt_q] <= in_if.byte_value;
    end
    if (mem_we && (lcnt_q == fptr_d)) begin
      rd_q <= in_if.byte_value;
    end else begin
      rd_q <= mem[fptr_d];
    end
  end

  // --------------------------------------------------------------------------
  // CRC accumulator
  // --------------------------------------------------------------------------
  swcf_pkg::crc_ctrl_t         crc_ctrl;
  logic [swcf_pkg::CRC_W-1:0]  crc;
  logic [swcf_pkg::BYTE_W-1:0] emit_byte;
  logic                        emit_last;

  assign emit_last = (pos_q == POS_CRC);

  always_comb begin
    if (pos_q == '0) begin
      emit_byte = hdr_q;
    end else if (emit_last) begin
      emit_byte = crc[7:0];
    end else begin
      emit_byte = rd_q;
    end
  end

  assign out_load = slot_free &&
                    ((state_q == swcf_pkg::ST_EMIT) || (state_q == swcf_pkg::ST_ACK));
  assign crc_ctrl = '{en:      out_load && (state_q == swcf_pkg::ST_EMIT) && !emit_last,
                      restart: (pos_q == '0)};

  swcf_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .byte_i (emit_byte),
    .crc_o  (crc)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    lcnt_d    = lcnt_q;
    rcnt_d    = rcnt_q;
    all_nak_d = all_nak_q;
    pos_d     = pos_q;
    fptr_d    = fptr_q;

    unique case (state_q)
      swcf_pkg::ST_LOAD: begin
        if (is_payload) begin
          if (lcnt_q == LAST_ADDR) begin
            lcnt_d  = '0;
            state_d = swcf_pkg::ST_EMIT;
            pos_d   = '0;
            fptr_d  = '0;
          end else begin
            lcnt_d = lcnt_q + 1'b1;
          end
        end
      end
      swcf_pkg::ST_WAIT: begin
        if (is_reply) begin
          if (rcnt_q == LAST_REPLY) begin
            rcnt_d    = '0;
            all_nak_d = 1'b1;
            pos_d     = '0;
            fptr_d    = '0;
            state_d   = reply_nak ? swcf_pkg::ST_EMIT : swcf_pkg::ST_ACK;
          end else begin
            rcnt_d    = rcnt_q + 1'b1;
            all_nak_d = reply_nak;
          end
        end
      end
      swcf_pkg::ST_EMIT: begin
        if (out_load) begin
          if (emit_last) begin
            state_d   = swcf_pkg::ST_WAIT;
            rcnt_d    = '0;
            all_nak_d = 1'b1;
          end else begin
            pos_d = pos_q + 1'b1;
            // a payload byte was taken from the read register: step the pointer
            if (pos_q != '0) begin
              fptr_d = (fptr_q == LAST_ADDR) ? '0 : fptr_q + 1'b1;
            end
          end
        end
      end
      swcf_pkg::ST_ACK: begin
        if (out_load) begin
          state_d = swcf_pkg::ST_LOAD;
          lcnt_d  = '0;
        end
      end
      default: state_d = swcf_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= swcf_pkg::ST_LOAD;
      lcnt_q    <= '0;
      rcnt_q    <= '0;
      all_nak_q <= 1'b1;
      pos_q     <= '0;
      fptr_q    <= '0;
    end else begin
      state_q   <= state_d;
      lcnt_q    <= lcnt_d;
      rcnt_q    <= rcnt_d;
      all_nak_q <= all_nak_d;
      pos_q     <= pos_d;
      fptr_q    <= fptr_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic                        out_kind_q, out_last_q;
  logic [swcf_pkg::BYTE_W-1:0] out_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (state_q == swcf_pkg::ST_ACK) begin
        out_kind_q <= swcf_pkg::KIND_ACK;
        out_byte_q <= '0;
        out_last_q <= 1'b1;
      end else begin
        out_kind_q <= swcf_pkg::KIND_FRAME;
        out_byte_q <= emit_byte;
        out_last_q <= emit_last;
      end
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.kind       = out_kind_q;
  assign out_if.tx_byte    = out_byte_q;
  assign out_if.frame_last = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a stray payload word while awaiting the reply leaves the reply tally alone
  a_payload_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_payload && (state_q == swcf_pkg::ST_WAIT))
      |=> (state_q == swcf_pkg::ST_WAIT) && $stable(rcnt_q) && $stable(all_nak_q))
    else $error("payload word disturbed reply collection");

  // the CRC byte of a frame always hands over to reply collection, fresh tally
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (state_q == swcf_pkg::ST_EMIT) && emit_last)
      |=> (state_q == swcf_pkg::ST_WAIT) && (rcnt_q == '0) && all_nak_q)
    else $error("frame end did not start reply collection");

  // an acknowledge restarts loading from an empty store
  a_ack_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (state_q == swcf_pkg::ST_ACK))
      |=> (state_q == swcf_pkg::ST_LOAD) && (lcnt_q == '0))
    else $error("acknowledge did not restart loading");

  // frame position never runs past the CRC byte
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swcf_pkg::ST_EMIT) |-> (pos_q <= POS_CRC))
    else $error("frame position out of range");

endmodule

@@ dv/swcf_checker.sv @@
// ----------------------------------------------------------------------------
// swcf_checker
// Watches both channels and the register port of the framer, keeps its own
// model of the frame, resend and acknowledge behaviour, and compares every
// accepted result word with the oldest word still owed.
// ----------------------------------------------------------------------------
module swcf_checker #(
  parameter int unsigned PAYLOAD_BYTES = 8,
  parameter int unsigned REPLY_BYTES   = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  swcf_in_if                             in_mon,
  swcf_out_if                            out_mon,
  input  logic                           cfg_we_i,
  input  logic [swcf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [swcf_pkg::BYTE_W-1:0]    cfg_data_i,
  input  logic                           end_check_i,
  output int                             owed_o,
  output int                             fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [swcf_pkg::CRC_W-1:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic                        kind;
    logic [swcf_pkg::BYTE_W-1:0] tx_byte;
    logic                        frame_last;
  } tx_word_t;

  tx_word_t                    owed_q[$];
  logic [swcf_pkg::BYTE_W-1:0] hdr_reg;
  logic [swcf_pkg::BYTE_W-1:0] nak_reg;
  logic [swcf_pkg::BYTE_W-1:0] held_payload [PAYLOAD_BYTES];
  int unsigned                 loaded;
  int unsigned                 replies;
  logic                        all_nak;
  logic                        awaiting;
  logic                        end_seen;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  function automatic tx_word_t mk_word(input logic k, input logic [swcf_pkg::BYTE_W-1:0] b,
                                       input logic l);
    tx_word_t w;
    w.kind       = k;
    w.tx_byte    = b;
    w.frame_last = l;
    return w;
  endfunction

  // bitwise CRC-16, msb first
  function automatic logic [swcf_pkg::CRC_W-1:0] crc_fold(
      input logic [swcf_pkg::CRC_W-1:0]  crc,
      input logic [swcf_pkg::BYTE_W-1:0] b);
    logic [swcf_pkg::CRC_W-1:0] c;
    int                         i;
    c = crc ^ {b, 8'h00};
    for (i = 0; i < 8; i++) c = c[swcf_pkg::CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // header, held payload, then CRC low byte; CRC always from scratch
  task automatic push_frame();
    logic [swcf_pkg::CRC_W-1:0] c;
    int                         i;
    c = crc_fold(swcf_pkg::CRC_INIT, hdr_reg);
    owed_q.push_back(mk_word(swcf_pkg::KIND_FRAME, hdr_reg, 1'b0));
    for (i = 0; i < PAYLOAD_BYTES; i++) begin
      c = crc_fold(c, held_payload[i]);
      owed_q.push_back(mk_word(swcf_pkg::KIND_FRAME, held_payload[i], 1'b0));
    end
    owed_q.push_back(mk_word(swcf_pkg::KIND_FRAME, c[swcf_pkg::BYTE_W-1:0], 1'b1));
  endtask

  task automatic framer_advance(input logic op, input logic [swcf_pkg::BYTE_W-1:0] b);
    if (op == swcf_pkg::OP_PAYLOAD) begin
      if (!awaiting) begin
        held_payload[loaded] = b;
        loaded++;
        if (loaded == PAYLOAD_BYTES) begin
          awaiting = 1'b1;
          replies  = 0;
          all_nak  = 1'b1;
          push_frame();
        end
      end
    end else if (awaiting) begin
      if (b != nak_reg) all_nak = 1'b0;
      replies++;
      if (replies == REPLY_BYTES) begin
        replies = 0;
        if (all_nak) begin
          push_frame();
        end else begin
          all_nak  = 1'b1;
          awaiting = 1'b0;
          loaded   = 0;
          owed_q.push_back(mk_word(swcf_pkg::KIND_ACK, '0, 1'b1));
        end
      end
    end
  endtask

  task automatic check_word(input tx_word_t got);
    tx_word_t want;
    if (owed_q.size() == 0) begin
      flag_mismatch($sformatf("unowed word kind=%0d byte=%02h last=%0d",
                              got.kind, got.tx_byte, got.frame_last));
    end else begin
      want = owed_q.pop_front();
      if (got.kind != want.kind)
        flag_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.tx_byte != want.tx_byte)
        flag_mismatch($sformatf("tx_byte %02h, want %02h", got.tx_byte, want.tx_byte));
      if (got.frame_last != want.frame_last)
        flag_mismatch($sformatf("frame_last %0d, want %0d",
                                got.frame_last, want.frame_last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q.delete();
      hdr_reg      = swcf_pkg::HEADER_RST;
      nak_reg      = swcf_pkg::NAK_RST;
      loaded       = 0;
      replies      = 0;
      all_nak      = 1'b1;
      awaiting     = 1'b0;
      end_seen     = 1'b0;
      owed_o       = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == swcf_pkg::REG_HEADER) hdr_reg = cfg_data_i;
        else if (cfg_idx_i == swcf_pkg::REG_NAK) nak_reg = cfg_data_i;
      end
      // results come from registers behind their cause, so check first
      if (out_mon.valid && out_mon.ready)
        check_word(mk_word(out_mon.kind, out_mon.tx_byte, out_mon.frame_last));
      if (in_mon.valid && in_mon.ready)
        framer_advance(in_mon.operation, in_mon.byte_value);
      if (end_check_i && !end_seen) begin
        end_seen = 1'b1;
        if (owed_q.size() != 0)
          flag_mismatch($sformatf("%0d words never produced", owed_q.size()));
      end
      owed_o = owed_q.size();
    end
  end

endmodule

@@ dv/stop_and_wait_crc_framer_tb.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_crc_framer_tb
// Drives payload and reply words into the framer under random idling on both
// channels, walks the header and NAK registers through several settings, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module stop_and_wait_crc_framer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAYLOAD_BYTES = 8;
  localparam int unsigned REPLY_BYTES   = 10;
  localparam int          CLK_PERIOD    = 12;
  localparam int          RESET_CYCLES  = 6;
  // a frame plus the CRC and RAM pipeline: enough for a busy block to go quiet
  localparam int          SETTLE_CYCLES = PAYLOAD_BYTES + 5;
  localparam int          HOLD_CYCLES   = 200;
  // several times the longest legal quiet spell (the long hold-off)
  localparam int          STALL_LIMIT   = 2000;
  localparam int          WORD_TARGET   = 300;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [swcf_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [swcf_pkg::BYTE_W-1:0]    cfg_data;
  logic                           end_check = 1'b0;
  int                             owed;
  int                             fail_count;

  // stimulus controls; hold_req and calm are shared with the receiver process
  logic                           hold_req = 1'b0;
  logic                           calm     = 1'b0;
  logic [swcf_pkg::BYTE_W-1:0]    cur_nak  = swcf_pkg::NAK_RST;
  int                             words_sent = 0;

  swcf_in_if  in_ch ();
  swcf_out_if out_ch ();

  stop_and_wait_crc_framer #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .REPLY_BYTES  (REPLY_BYTES)
  ) uut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  swcf_checker #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .REPLY_BYTES  (REPLY_BYTES)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .end_check_i (end_check),
    .owed_o      (owed),
    .fail_count_o(fail_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one word from a falling edge and hold it until the rising edge that
  // takes it. Outside the calm tail a random gap may come first.
  task automatic send_word(input logic op, input logic [swcf_pkg::BYTE_W-1:0] b);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.byte_value <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Eight payload words; a stray reply word now and then is ignored by the
  // block while loading, so it does not count.
  task automatic load_frame();
    int i;
    for (i = 0; i < PAYLOAD_BYTES; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(swcf_pkg::OP_REPLY, 8'($urandom));
      send_word(swcf_pkg::OP_PAYLOAD, 8'($urandom));
      words_sent++;
    end
  endtask

  // One full reply. all_nak asks for a resend; otherwise at least one word
  // differs from the NAK value and the frame gets acknowledged.
  task automatic reply_round(input logic all_nak);
    int                          i;
    int                          bad_pos;
    logic [swcf_pkg::BYTE_W-1:0] b;
    bad_pos = $urandom_range(0, REPLY_BYTES - 1);
    for (i = 0; i < REPLY_BYTES; i++) begin
      // stray payload word while awaiting a reply: ignored by the block
      if ($urandom_range(0, 9) == 0) send_word(swcf_pkg::OP_PAYLOAD, 8'($urandom));
      if (all_nak) b = cur_nak;
      else if (i == bad_pos) b = cur_nak ^ 8'($urandom_range(1, 255));
      else if ($urandom_range(0, 3) == 0) b = 8'($urandom);
      else b = cur_nak;
      send_word(swcf_pkg::OP_REPLY, b);
      words_sent++;
    end
  endtask

  // load, zero to two resends, then the acknowledge
  task automatic run_exchange();
    load_frame();
    repeat ($urandom_range(0, 2)) reply_round(1'b1);
    reply_round(1'b0);
  endtask

  task automatic run_until(input int goal);
    while (words_sent < goal) run_exchange();
  endtask

  // Drop valid, wait for every owed word, then give the pipeline time to
  // finish anything that owes nothing.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(input logic [swcf_pkg::BYTE_W-1:0] hdr,
                            input logic [swcf_pkg::BYTE_W-1:0] nak);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= swcf_pkg::REG_HEADER;
    cfg_data <= hdr;
    @(negedge clk);
    cfg_idx  <= swcf_pkg::REG_NAK;
    cfg_data <= nak;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_nak = nak;
  endtask

  // Directed opening on reset register values: both kinds of ignored word,
  // extreme payload bytes, a resend and an acknowledge whose only non-NAK
  // word is the last one.
  task automatic run_directed();
    logic [swcf_pkg::BYTE_W-1:0] corner_bytes [PAYLOAD_BYTES];
    int                          i;
    corner_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'hFE};
    send_word(swcf_pkg::OP_REPLY, swcf_pkg::NAK_RST);     // reply while loading
    for (i = 0; i < PAYLOAD_BYTES; i++) begin
      send_word(swcf_pkg::OP_PAYLOAD, corner_bytes[i]);
      words_sent++;
    end
    send_word(swcf_pkg::OP_PAYLOAD, 8'hC3);               // payload while awaiting reply
    reply_round(1'b1);
    for (i = 0; i < REPLY_BYTES; i++) begin
      send_word(swcf_pkg::OP_REPLY,
                (i == REPLY_BYTES - 1) ? swcf_pkg::NAK_RST + 8'd1 : swcf_pkg::NAK_RST);
      words_sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stall bursts, one long hold-off on request, and
  // always ready in the calm tail.
  // --------------------------------------------------------------------------
  initial begin : receiver
    logic hold_done;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no word moving on either channel ends the run.
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = swcf_pkg::OP_PAYLOAD;
    in_ch.byte_value = '0;
    cfg_we           = 1'b0;
    cfg_idx          = swcf_pkg::REG_HEADER;
    cfg_data         = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    // all-zero registers: header 00, and a NAK that matches a zero reply
    settle();
    write_regs(8'h00, 8'h00);
    run_until(words_sent + 60);

    // all-ones registers, plus the long hold-off: the frame stalls on the
    // result side while replies keep being offered, so input backs up
    settle();
    write_regs(8'hFF, 8'hFF);
    load_frame();
    hold_req = 1'b1;
    reply_round(1'b1);
    reply_round(1'b0);
    run_until(words_sent + 50);

    // registers changed while a frame awaits its reply: the new NAK decides
    // the reply and the new header goes out on the resend
    settle();
    load_frame();
    settle();
    write_regs(8'($urandom), 8'($urandom));
    reply_round(1'b1);
    reply_round(1'b0);
    run_until(words_sent + 50);

    // calm tail on a fresh random setting, no idling on either side
    settle();
    write_regs(8'($urandom), 8'($urandom));
    @(posedge clk);
    calm = 1'b1;
    run_until(WORD_TARGET);

    settle();
    end_check = 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ stop_and_wait_crc_framer.f @@
rtl/swcf_pkg.sv
rtl/swcf_in_if.sv
rtl/swcf_out_if.sv
rtl/swcf_crc.sv
rtl/stop_and_wait_crc_framer.sv
dv/swcf_checker.sv
dv/stop_and_wait_crc_framer_tb.sv
